### sv/rbmj_pkg.sv
// Shared types, constants and the per-stage datapath function of the range/bearing core.
`default_nettype none
package rbmj_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_MAX = 32;

  // Pipeline stage positions
  localparam int P_DIFF      = 0;
  localparam int P_ABS       = 1;
  localparam int P_MUL       = 2;
  localparam int P_SUM       = 3;
  localparam int P_ROOT0     = 4;
  localparam int P_ROOT_LAST = 36;
  localparam int P_DIV0      = 37;
  localparam int P_DIV_LAST  = 52;
  localparam int P_OUT       = 53;
  localparam int NUM_STAGES  = 54;

  localparam int ADDR_W = 2;
  localparam logic [ADDR_W-1:0] ADDR_MIN_RANGE_SQ = 2'd0;
  localparam logic [31:0] MIN_RANGE_SQ_RST = 32'd43;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic signed [31:0] ugv_e;
    logic signed [31:0] ugv_n;
    logic signed [31:0] uav_e;
    logic signed [31:0] uav_n;
    logic [15:0]        gh;
    logic [15:0]        ah;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [31:0]        adx;
    logic [31:0]        ady;
    logic [31:0]        phx;
    logic [31:0]        pmx;
    logic [31:0]        plx;
    logic [31:0]        phy;
    logic [31:0]        pmy;
    logic [31:0]        ply;
    logic [64:0]        r2;
    logic               zero;
    logic               close;
    logic signed [36:0] cx;
    logic signed [36:0] cy;
    logic [31:0]        cz;
    logic [65:0]        srem;
    logic [32:0]        sroot;
    logic [63:0]        rx2;
    logic [63:0]        ry2;
    logic [32:0]        qx2;
    logic [32:0]        qy2;
    logic [32:0]        rxr;
    logic [32:0]        ryr;
    logic [15:0]        qxr;
    logic [15:0]        qyr;
    logic [15:0]        bu;
    logic [15:0]        ba;
    logic [31:0]        rng;
    logic [31:0]        gx2;
    logic [31:0]        gy2;
    logic [15:0]        gxr;
    logic [15:0]        gyr;
  } stage_t;

  function automatic logic [31:0] sat32(input logic [32:0] q, input logic neg);
    logic [32:0] lim;
    logic [32:0] m;
    lim = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    m = (q > lim) ? lim : q;
    return neg ? 32'(-m) : m[31:0];
  endfunction

  function automatic logic [15:0] sat16(input logic [15:0] q, input logic neg);
    logic [15:0] lim;
    logic [15:0] m;
    lim = neg ? 16'h8000 : 16'h7FFF;
    m = (q > lim) ? lim : q;
    return neg ? 16'(-m) : m;
  endfunction

  // Work of pipeline stage p on the item it receives
  function automatic stage_t step(input int p, input int cs, input stage_t si,
                                  input logic [31:0] thr);
    stage_t s;
    int b;
    int i;
    logic [66:0] trial;
    logic [64:0] t1;
    logic [64:0] t2;
    logic [33:0] t3;
    logic [33:0] t4;
    logic signed [36:0] xs;
    logic signed [36:0] ys;
    logic [31:0] rnd;
    logic [15:0] b16;
    logic gz;
    s = si;
    if (p == P_DIFF) begin
      s.dx = 33'(s.uav_e) - 33'(s.ugv_e);
      s.dy = 33'(s.uav_n) - 33'(s.ugv_n);
    end
    if (p == P_ABS) begin
      s.adx = s.dx[32] ? 32'(-s.dx) : s.dx[31:0];
      s.ady = s.dy[32] ? 32'(-s.dy) : s.dy[31:0];
      s.zero = (s.dx == 33'sd0) && (s.dy == 33'sd0);
      // turn a left-half vector by a half turn
      if (s.dx[32]) begin
        s.cx = -37'(s.dx);
        s.cy = -37'(s.dy);
        s.cz = 32'h8000_0000;
      end else begin
        s.cx = 37'(s.dx);
        s.cy = 37'(s.dy);
        s.cz = 32'h0;
      end
    end
    if (p == P_MUL) begin
      s.phx = {16'b0, s.adx[31:16]} * {16'b0, s.adx[31:16]};
      s.pmx = {16'b0, s.adx[31:16]} * {16'b0, s.adx[15:0]};
      s.plx = {16'b0, s.adx[15:0]} * {16'b0, s.adx[15:0]};
      s.phy = {16'b0, s.ady[31:16]} * {16'b0, s.ady[31:16]};
      s.pmy = {16'b0, s.ady[31:16]} * {16'b0, s.ady[15:0]};
      s.ply = {16'b0, s.ady[15:0]} * {16'b0, s.ady[15:0]};
    end
    if (p == P_SUM) begin
      s.r2 = {1'b0, s.phx, 32'b0} + (65'(s.pmx) << 17) + 65'(s.plx)
           + {1'b0, s.phy, 32'b0} + (65'(s.pmy) << 17) + 65'(s.ply);
    end
    if (p >= P_MUL && p < P_MUL + cs && p - P_MUL < CORDIC_MAX) begin
      i = p - P_MUL;
      xs = s.cx >>> i;
      ys = s.cy >>> i;
      if (!s.cy[36]) begin
        s.cx = s.cx + ys;
        s.cy = s.cy - xs;
        s.cz = s.cz + ATAN_TAB[5'(i)];
      end else begin
        s.cx = s.cx - ys;
        s.cy = s.cy + xs;
        s.cz = s.cz - ATAN_TAB[5'(i)];
      end
    end
    if (p == P_ROOT0) begin
      s.close = !s.r2[64] && (s.r2[63:0] < {32'b0, thr});
      s.srem = {1'b0, s.r2};
      s.sroot = '0;
      s.rx2 = 64'(s.adx >> 1);
      s.ry2 = 64'(s.ady >> 1);
      s.qx2 = '0;
      s.qy2 = '0;
    end
    if (p >= P_ROOT0 && p <= P_ROOT_LAST) begin
      b = P_ROOT_LAST - p;
      trial = (67'(s.sroot) << (b + 1)) + (67'd1 << (2 * b));
      if (67'(s.srem) >= trial) begin
        s.srem = 66'(67'(s.srem) - trial);
        s.sroot[b] = 1'b1;
      end
      // r^2 dividers: one quotient bit per stage
      t1 = {s.rx2, (b == 32) ? s.adx[0] : 1'b0};
      if (t1 >= {1'b0, s.r2[63:0]}) begin
        s.rx2 = 64'(t1 - {1'b0, s.r2[63:0]});
        s.qx2[b] = 1'b1;
      end else begin
        s.rx2 = t1[63:0];
      end
      t2 = {s.ry2, (b == 32) ? s.ady[0] : 1'b0};
      if (t2 >= {1'b0, s.r2[63:0]}) begin
        s.ry2 = 64'(t2 - {1'b0, s.r2[63:0]});
        s.qy2[b] = 1'b1;
      end else begin
        s.ry2 = t2[63:0];
      end
    end
    if (p == P_DIV0) begin
      s.rxr = 33'(s.adx >> 1);
      s.ryr = 33'(s.ady >> 1);
      s.qxr = '0;
      s.qyr = '0;
    end
    if (p >= P_DIV0 && p <= P_DIV_LAST) begin
      b = P_DIV_LAST - p;
      t3 = {s.rxr, (b == 15) ? s.adx[0] : 1'b0};
      if (t3 >= {1'b0, s.sroot}) begin
        s.rxr = 33'(t3 - {1'b0, s.sroot});
        s.qxr[b] = 1'b1;
      end else begin
        s.rxr = t3[32:0];
      end
      t4 = {s.ryr, (b == 15) ? s.ady[0] : 1'b0};
      if (t4 >= {1'b0, s.sroot}) begin
        s.ryr = 33'(t4 - {1'b0, s.sroot});
        s.qyr[b] = 1'b1;
      end else begin
        s.ryr = t4[32:0];
      end
    end
    if (p == P_OUT) begin
      rnd = s.cz + 32'h0000_8000;
      b16 = s.zero ? 16'h0 : rnd[31:16];
      s.bu = b16 - s.gh;
      s.ba = s.zero ? (16'h0 - s.ah) : (b16 + 16'h8000 - s.ah);
      s.rng = s.sroot[32] ? 32'hFFFF_FFFF : s.sroot[31:0];
      gz = !s.close && (s.sroot != 33'd0);
      s.gx2 = (gz && !s.r2[64]) ? sat32(s.qx2, s.dx[32]) : 32'h0;
      s.gy2 = (gz && !s.r2[64]) ? sat32(s.qy2, s.dy[32]) : 32'h0;
      s.gxr = gz ? sat16(s.qxr, s.dx[32]) : 16'h0;
      s.gyr = gz ? sat16(s.qyr, s.dy[32]) : 16'h0;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

### sv/rbmj_stage.sv
// One register stage of the range/bearing pipeline with its valid bit and stall flow.
`default_nettype none
module rbmj_stage #(
  parameter int STAGE = 0,
  parameter int CORDIC_STAGES = rbmj_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [31:0]      thr,
  input  wire logic             up_valid,
  input  wire rbmj_pkg::stage_t up_data,
  output logic                  up_ready,
  output logic                  dn_valid,
  output rbmj_pkg::stage_t      dn_data,
  input  wire logic             dn_ready
);

  // advance when empty or when the next stage takes our item
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= rbmj_pkg::step(STAGE, CORDIC_STAGES, up_data, thr);
    end
  end

endmodule
`default_nettype wire

### sv/range_bearing_measurement_jacobian_core.sv
// Top level of the range/bearing measurement core with gradient terms.
//
//  channel  | handshake                  | content
//  ---------+----------------------------+-------------------------------------------
//  in       | in_valid / in_stall        | ugv and uav positions and headings
//  out      | out_valid / out_stall      | bearings, range, uav position, gradients, too_close
//  cfg      | APB psel/penable/pwrite    | min_range_sq at byte address 0
//
// 54 register stages, each item registered through all of them in order; one item per
// cycle sustained while out_stall stays low.
// The 33-stage square root, one root bit per stage, followed by the 16-stage
// quotient for dx/r and dy/r sets the depth; CORDIC and r^2 quotients run alongside.
// Reset clears every stage valid bit and loads min_range_sq with 43.
// A stall only holds full stages; empty stages keep filling, so bubbles collapse.
`default_nettype none
module range_bearing_measurement_jacobian_core #(
  parameter int CORDIC_STAGES = rbmj_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rbmj_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [31:0]            ugv_east,
  input  wire logic signed [31:0]            ugv_north,
  input  wire logic signed [15:0]            ugv_heading,
  input  wire logic signed [31:0]            uav_east,
  input  wire logic signed [31:0]            uav_north,
  input  wire logic signed [15:0]            uav_heading,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [15:0]                 bearing_from_ugv,
  output logic        [31:0]                 range_out,
  output logic signed [15:0]                 bearing_from_uav,
  output logic signed [31:0]                 uav_east_out,
  output logic signed [31:0]                 uav_north_out,
  output logic signed [31:0]                 dy_over_r2,
  output logic signed [31:0]                 dx_over_r2,
  output logic signed [15:0]                 dx_over_r,
  output logic signed [15:0]                 dy_over_r,
  output logic                               too_close
);

  localparam int NS = rbmj_pkg::NUM_STAGES;

  logic [31:0]       min_range_sq;
  logic [NS:0]       vin;
  logic [NS:0]       rdy;
  rbmj_pkg::stage_t  din [NS+1];
  rbmj_pkg::stage_t  in_pkt;

  assign pready = 1'b1;
  assign prdata = (paddr == rbmj_pkg::ADDR_MIN_RANGE_SQ) ? min_range_sq : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_range_sq <= rbmj_pkg::MIN_RANGE_SQ_RST;
    end else if (psel && penable && pwrite && paddr == rbmj_pkg::ADDR_MIN_RANGE_SQ) begin
      min_range_sq <= pwdata;
    end
  end

  always_comb begin
    in_pkt = '0;
    in_pkt.ugv_e = ugv_east;
    in_pkt.ugv_n = ugv_north;
    in_pkt.uav_e = uav_east;
    in_pkt.uav_n = uav_north;
    in_pkt.gh = ugv_heading;
    in_pkt.ah = uav_heading;
  end

  assign vin[0] = in_valid;
  assign din[0] = in_pkt;
  assign rdy[NS] = !out_stall;
  assign in_stall = !rdy[0];

  for (genvar p = 0; p < NS; p++) begin : g_stage
    rbmj_stage #(
      .STAGE(p),
      .CORDIC_STAGES(CORDIC_STAGES)
    ) u_stage (
      .clk(clk),
      .rst(rst),
      .thr(min_range_sq),
      .up_valid(vin[p]),
      .up_data(din[p]),
      .up_ready(rdy[p]),
      .dn_valid(vin[p+1]),
      .dn_data(din[p+1]),
      .dn_ready(rdy[p+1])
    );
  end

  assign out_valid = vin[NS];
  assign bearing_from_ugv = din[NS].bu;
  assign range_out = din[NS].rng;
  assign bearing_from_uav = din[NS].ba;
  assign uav_east_out = din[NS].uav_e;
  assign uav_north_out = din[NS].uav_n;
  assign dy_over_r2 = din[NS].gy2;
  assign dx_over_r2 = din[NS].gx2;
  assign dx_over_r = din[NS].gxr;
  assign dy_over_r = din[NS].gyr;
  assign too_close = din[NS].close;

`ifndef SYNTH
  a_close_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_close |->
      dx_over_r == 16'sd0 && dy_over_r == 16'sd0 && dx_over_r2 == 32'sd0 &&
      dy_over_r2 == 32'sd0)
    else $error("gradients not zero while too close");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> &vin[NS:1])
    else $error("input stalled with an empty stage");
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vin[1])
    else $error("accepted item not captured by first stage");
`endif

endmodule
`default_nettype wire

### sim/range_bearing_measurement_jacobian_core_test.sv
// Testbench for the range/bearing measurement core: directed and random vehicle pairs.
module range_bearing_measurement_jacobian_core_test;

  localparam int STAGES = rbmj_pkg::CORDIC_STAGES_DEF;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [15:0] bearing_ugv;
    logic [31:0] range_m;
    logic [15:0] bearing_uav;
    logic [31:0] uav_e;
    logic [31:0] uav_n;
    logic [31:0] dy_r2;
    logic [31:0] dx_r2;
    logic [15:0] dx_r;
    logic [15:0] dy_r;
    logic        close;
  } meas_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [rbmj_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] ugv_east = '0;
  logic signed [31:0] ugv_north = '0;
  logic signed [15:0] ugv_heading = '0;
  logic signed [31:0] uav_east = '0;
  logic signed [31:0] uav_north = '0;
  logic signed [15:0] uav_heading = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] bearing_from_ugv;
  logic [31:0] range_out;
  logic signed [15:0] bearing_from_uav;
  logic signed [31:0] uav_east_out;
  logic signed [31:0] uav_north_out;
  logic signed [31:0] dy_over_r2;
  logic signed [31:0] dx_over_r2;
  logic signed [15:0] dx_over_r;
  logic signed [15:0] dy_over_r;
  logic too_close;

  meas_t pending_meas[$];
  logic [31:0] range_sq_floor = rbmj_pkg::MIN_RANGE_SQ_RST;
  int error_count = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_phase = 0;

  range_bearing_measurement_jacobian_core DUT (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .ugv_east, .ugv_north, .ugv_heading,
    .uav_east, .uav_north, .uav_heading,
    .out_valid, .out_stall, .bearing_from_ugv, .range_out, .bearing_from_uav,
    .uav_east_out, .uav_north_out, .dy_over_r2, .dx_over_r2, .dx_over_r, .dy_over_r,
    .too_close
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 3_000_000);
    $display("range_bearing_measurement_jacobian_core_test failed");
    $finish;
  end

  function automatic logic [31:0] clamp_mag(input logic [95:0] q, input bit neg,
                                            input logic [95:0] posmax);
    logic [95:0] lim;
    lim = neg ? posmax + 96'd1 : posmax;
    if (q > lim) q = lim;
    return neg ? 32'(-q) : q[31:0];
  endfunction

  function automatic meas_t predict_measurement(input logic signed [31:0] ge, gn, ae, an,
                                                input logic [15:0] gh, ah);
    meas_t m;
    longint dx;
    longint dy;
    longint cx;
    longint cy;
    longint xs;
    longint ys;
    logic [31:0] adx;
    logic [31:0] ady;
    logic [64:0] r2;
    logic [32:0] root;
    logic [32:0] cand;
    logic [31:0] z;
    logic [31:0] rnd;
    logic [15:0] b16;
    bit zero;
    dx = longint'(ae) - longint'(ge);
    dy = longint'(an) - longint'(gn);
    adx = 32'(dx < 0 ? -dx : dx);
    ady = 32'(dy < 0 ? -dy : dy);
    r2 = 65'(adx) * 65'(adx) + 65'(ady) * 65'(ady);
    root = '0;
    for (int k = 32; k >= 0; k--) begin
      cand = root | (33'd1 << k);
      if (67'(cand) * 67'(cand) <= 67'(r2)) root = cand;
    end
    zero = (dx == 0) && (dy == 0);
    z = '0;
    if (!zero) begin
      cx = dx;
      cy = dy;
      if (cx < 0) begin
        cx = -cx;
        cy = -cy;
        z = 32'h8000_0000;
      end
      for (int i = 0; i < STAGES && i < 32; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (cy >= 0) begin
          cx += ys; cy -= xs; z += rbmj_pkg::ATAN_TAB[i];
        end else begin
          cx -= ys; cy += xs; z -= rbmj_pkg::ATAN_TAB[i];
        end
      end
    end
    rnd = z + 32'h0000_8000;
    b16 = rnd[31:16];
    m.bearing_ugv = b16 - gh;
    m.range_m = root[32] ? 32'hFFFF_FFFF : root[31:0];
    m.bearing_uav = zero ? 16'h0 - ah : b16 + 16'h8000 - ah;
    m.uav_e = ae;
    m.uav_n = an;
    m.close = !r2[64] && (r2[63:0] < 64'(range_sq_floor));
    m.dy_r2 = '0; m.dx_r2 = '0; m.dx_r = '0; m.dy_r = '0;
    if (!m.close && root != 0) begin
      if (!r2[64]) begin
        m.dy_r2 = clamp_mag({ady, 32'b0} / 96'(r2[63:0]), dy < 0, 96'h7FFF_FFFF);
        m.dx_r2 = clamp_mag({adx, 32'b0} / 96'(r2[63:0]), dx < 0, 96'h7FFF_FFFF);
      end
      m.dx_r = 16'(clamp_mag(96'({adx, 15'b0}) / 96'(root), dx < 0, 96'h7FFF));
      m.dy_r = 16'(clamp_mag(96'({ady, 15'b0}) / 96'(root), dy < 0, 96'h7FFF));
    end
    return m;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $time);
    error_count++;
  endtask

  // result checking and receiver stall pattern
  always @(posedge clk) begin
    meas_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_meas.size() == 0) begin
          report_mismatch("unexpected result", range_out, 32'h0);
        end else begin
          want = pending_meas.pop_front();
          if (bearing_from_ugv !== want.bearing_ugv)
            report_mismatch("bearing_from_ugv", 32'(bearing_from_ugv), 32'(want.bearing_ugv));
          if (range_out !== want.range_m) report_mismatch("range_out", range_out, want.range_m);
          if (bearing_from_uav !== want.bearing_uav)
            report_mismatch("bearing_from_uav", 32'(bearing_from_uav), 32'(want.bearing_uav));
          if (uav_east_out !== want.uav_e)
            report_mismatch("uav_east_out", uav_east_out, want.uav_e);
          if (uav_north_out !== want.uav_n)
            report_mismatch("uav_north_out", uav_north_out, want.uav_n);
          if (dy_over_r2 !== want.dy_r2) report_mismatch("dy_over_r2", dy_over_r2, want.dy_r2);
          if (dx_over_r2 !== want.dx_r2) report_mismatch("dx_over_r2", dx_over_r2, want.dx_r2);
          if (dx_over_r !== want.dx_r)
            report_mismatch("dx_over_r", 32'(dx_over_r), 32'(want.dx_r));
          if (dy_over_r !== want.dy_r)
            report_mismatch("dy_over_r", 32'(dy_over_r), 32'(want.dy_r));
          if (too_close !== want.close)
            report_mismatch("too_close", 32'(too_close), 32'(want.close));
        end
      end
      // pick a new random stall mode each time stall_phase is a multiple of 64
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic write_floor(input logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= rbmj_pkg::ADDR_MIN_RANGE_SQ; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    range_sq_floor = value;
  endtask

  task automatic send_pair(input logic [31:0] ge, gn, ae, an, input logic [15:0] gh, ah);
    in_valid <= 1'b1;
    ugv_east <= ge; ugv_north <= gn; ugv_heading <= gh;
    uav_east <= ae; uav_north <= an; uav_heading <= ah;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_meas.push_back(predict_measurement(ge, gn, ae, an, gh, ah));
    // close a burst and hold off for a random gap
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_meas.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] offset(input int lo, input int hi);
    return 32'($signed($urandom_range(0, hi - lo)) + lo);
  endfunction

  task automatic send_random(input int count);
    logic [31:0] ge;
    logic [31:0] gn;
    logic [31:0] ae;
    logic [31:0] an;
    int kind;
    for (int n = 0; n < count; n++) begin
      ge = $urandom; gn = $urandom;
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin ae = $urandom; an = $urandom; end
        4, 5, 6: begin ae = ge + offset(-200000, 200000); an = gn + offset(-200000, 200000); end
        7: begin ae = ge + offset(-8, 8); an = gn + offset(-8, 8); end
        8: begin
          if ($urandom_range(0, 1)) begin ae = ge; an = $urandom; end
          else begin ae = $urandom; an = gn; end
        end
        default: begin ae = ge; an = gn; end
      endcase
      send_pair(ge, gn, ae, an, 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_directed();
    send_pair(32'd0, 32'd0, 32'd0, 32'd0, 16'h1234, 16'h8000);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0, 16'h0);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'h7FFF, 16'h8000);
    send_pair(32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'd0, 16'hFFFF, 16'h0001);
    send_pair(32'd0, 32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 16'h0, 16'h0);
    send_pair(32'd0, 32'd0, 32'd1, 32'd0, 16'h0, 16'h0);
    send_pair(32'd0, 32'd0, 32'd6, 32'd0, 16'h0, 16'h0);
    send_pair(32'd0, 32'd0, 32'd7, 32'd0, 16'h0, 16'h0);
    send_pair(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 16'h0);
    send_pair(32'd100, 32'd0, 32'd0, 32'd0, 16'h8000, 16'h0);
    send_pair(32'd0, 32'd0, 32'h0001_0000, 32'd0, 16'h8000, 16'h8000);
    send_pair(32'd0, 32'd0, 32'hFFFF_0000, 32'd0, 16'h0, 16'h0);
    send_pair(32'd0, 32'd0, 32'd0, 32'h0010_0000, 16'h4000, 16'hC000);
    send_pair(32'd5, 32'd5, 32'd5, 32'hFFF0_0000, 16'h0, 16'h0);
    send_pair(32'd0, 32'd0, 32'h0003_0000, 32'h0004_0000, 16'h5555, 16'hAAAA);
    send_pair(32'd0, 32'd0, 32'hFFFD_0000, 32'hFFFC_0000, 16'h0, 16'h0);
    send_pair(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0, 16'h0, 16'h7FFF);
    wait_drained();
  endtask

  task automatic test_zero_floor();
    write_floor(32'd0);
    send_pair(32'd0, 32'd0, 32'd0, 32'd0, 16'h0, 16'h0);
    send_pair(32'd0, 32'd0, 32'd1, 32'd1, 16'h0, 16'h0);
    send_pair(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 16'h0, 16'h0);
    send_random(400);
    wait_drained();
  endtask

  task automatic test_max_floor();
    write_floor(32'hFFFF_FFFF);
    send_pair(32'd0, 32'd0, 32'h0001_0000, 32'd0, 16'h0, 16'h0);
    send_pair(32'd0, 32'd0, 32'h0000_FFFF, 32'd0, 16'h0, 16'h0);
    send_random(350);
    wait_drained();
  endtask

  task automatic test_default_floor_with_pause();
    write_floor(rbmj_pkg::MIN_RANGE_SQ_RST);
    send_random(200);
    // hold off until every result has come back
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_meas.size() != 0) @(posedge clk);
    send_random(200);
    wait_drained();
  endtask

  task automatic test_random_floors();
    for (int k = 0; k < 4; k++) begin
      write_floor(($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 1000));
      send_random(125);
      wait_drained();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_zero_floor();
    test_max_floor();
    test_default_floor_with_pause();
    test_random_floors();
    if (error_count == 0 && pending_meas.size() == 0) begin
      $display("range_bearing_measurement_jacobian_core_test passed");
    end else begin
      $display("range_bearing_measurement_jacobian_core_test failed");
    end
    $finish;
  end

endmodule
